FILE: hw/rtl/clkpr_pkg.sv
// ----------------------------------------------------------------------------
// clkpr_pkg
// Shared types and constants for the clock (second-chance) page replacer.
// ----------------------------------------------------------------------------
package clkpr_pkg;

  localparam int NUM_FRAMES_DEFAULT = 64;

  localparam int MODE_W  = 2;
  localparam int FRAME_W = 6;
  localparam int COUNT_W = 7;

  localparam logic [COUNT_W-1:0] CAPACITY_RESET = 7'd64;

  // request kinds; the fourth code is unused and changes nothing
  typedef enum logic [MODE_W-1:0] {
    MODE_VICTIM = 2'd0,
    MODE_PIN    = 2'd1,
    MODE_UNPIN  = 2'd2
  } mode_t;

  // frame table address source
  typedef enum logic [1:0] {
    ADDR_CLEAR = 2'd0,
    ADDR_HAND  = 2'd1,
    ADDR_FRAME = 2'd2
  } addr_sel_t;

  typedef struct packed {
    addr_sel_t addr_sel;
    logic      wr_en;
    logic      wr_ev;
    logic      wr_ref;
    logic      clear_adv;
    logic      latch;
    logic      hand_adv;
    logic      total_inc;
    logic      total_dec;
    logic      set_victim;
    logic      set_refused;
    logic      load_out;
  } clkpr_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              clear_last;
    logic              total_zero;
    logic              in_range;
    logic              cap_full;
    logic              slot_ev;
    logic              slot_ref;
  } clkpr_status_t;

endpackage

FILE: hw/rtl/clkpr_ram.sv
// ----------------------------------------------------------------------------
// clkpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module clkpr_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/clkpr_datapath.sv
// ----------------------------------------------------------------------------
// clkpr_datapath
// Frame table, clock hand, evictable total, capacity and result registers.
// ----------------------------------------------------------------------------
module clkpr_datapath #(
  parameter int NUM_FRAMES = clkpr_pkg::NUM_FRAMES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  clkpr_pkg::clkpr_cmd_t             cmd,
  output clkpr_pkg::clkpr_status_t          status,
  input  logic [clkpr_pkg::MODE_W-1:0]      mode,
  input  logic [clkpr_pkg::FRAME_W-1:0]     frame,
  input  logic                              cfg_write,
  input  logic [clkpr_pkg::COUNT_W-1:0]     cfg_data,
  output logic                              victim_valid,
  output logic [clkpr_pkg::FRAME_W-1:0]     victim_frame,
  output logic                              refused,
  output logic [clkpr_pkg::COUNT_W-1:0]     evictable_count
);

  localparam int AW = $clog2(NUM_FRAMES);
  localparam logic [AW-1:0] LAST_FRAME = AW'(NUM_FRAMES - 1);

  logic [AW-1:0]                   clear_addr;
  logic [AW-1:0]                   hand;
  logic [clkpr_pkg::COUNT_W-1:0]   total;
  logic [clkpr_pkg::COUNT_W-1:0]   capacity;
  logic [clkpr_pkg::MODE_W-1:0]    req_mode;
  logic [clkpr_pkg::FRAME_W-1:0]   req_frame;
  logic                            res_valid;
  logic [clkpr_pkg::FRAME_W-1:0]   res_frame;
  logic                            res_refused;

  logic [AW-1:0] frame_addr;
  logic [AW-1:0] addr;
  logic [1:0]    wr_word;
  logic [1:0]    rd_word;

  assign frame_addr = AW'({{(32-clkpr_pkg::FRAME_W){1'b0}}, req_frame});

  always_comb begin
    unique case (cmd.addr_sel)
      clkpr_pkg::ADDR_CLEAR: addr = clear_addr;
      clkpr_pkg::ADDR_HAND:  addr = hand;
      clkpr_pkg::ADDR_FRAME: addr = frame_addr;
      default:               addr = hand;
    endcase
  end

  assign wr_word = {cmd.wr_ev, cmd.wr_ref};

  clkpr_ram #(
    .WIDTH (2),
    .DEPTH (NUM_FRAMES)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (addr),
    .wr_data (wr_word),
    .rd_addr (addr),
    .rd_data (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
      hand       <= '0;
      total      <= '0;
      capacity   <= clkpr_pkg::CAPACITY_RESET;
    end else begin
      if (cmd.clear_adv) begin
        clear_addr <= (clear_addr == LAST_FRAME) ? '0 : clear_addr + 1'b1;
      end
      if (cmd.hand_adv) begin
        hand <= (hand == LAST_FRAME) ? '0 : hand + 1'b1;
      end
      if (cmd.total_inc) begin
        total <= total + 1'b1;
      end else if (cmd.total_dec) begin
        total <= total - 1'b1;
      end
      if (cfg_write) begin
        capacity <= cfg_data;
      end
    end
  end

  // request and result holding
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_mode    <= mode;
      req_frame   <= frame;
      res_valid   <= 1'b0;
      res_frame   <= '0;
      res_refused <= 1'b0;
    end else begin
      if (cmd.set_victim) begin
        res_valid <= 1'b1;
        res_frame <= clkpr_pkg::FRAME_W'({{(32-AW){1'b0}}, hand});
      end
      if (cmd.set_refused) begin
        res_refused <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      victim_valid    <= res_valid;
      victim_frame    <= res_frame;
      refused         <= res_refused;
      evictable_count <= total;
    end
  end

  always_comb begin
    status.mode       = req_mode;
    status.clear_last = (clear_addr == LAST_FRAME);
    status.total_zero = (total == '0);
    status.in_range   = ({{(32-clkpr_pkg::FRAME_W){1'b0}}, req_frame} < 32'(NUM_FRAMES));
    status.cap_full   = (total >= capacity);
    status.slot_ev    = rd_word[1];
    status.slot_ref   = rd_word[0];
  end

endmodule

FILE: hw/rtl/clkpr_ctrl.sv
// ----------------------------------------------------------------------------
// clkpr_ctrl
// Sequencer for table clearing, request dispatch, clock sweep and output.
// ----------------------------------------------------------------------------
module clkpr_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [clkpr_pkg::MODE_W-1:0]  mode,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  clkpr_pkg::clkpr_status_t      status,
  output clkpr_pkg::clkpr_cmd_t         cmd
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_VREAD = 7'b0000100,
    S_VEVAL = 7'b0001000,
    S_FREAD = 7'b0010000,
    S_FEVAL = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_fire;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.addr_sel = clkpr_pkg::ADDR_HAND;
    unique case (state)
      S_CLEAR: begin
        cmd.addr_sel  = clkpr_pkg::ADDR_CLEAR;
        cmd.wr_en     = 1'b1;
        cmd.clear_adv = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd.latch = 1'b1;
          unique case (mode) inside
            clkpr_pkg::MODE_VICTIM:                     state_next = S_VREAD;
            clkpr_pkg::MODE_PIN, clkpr_pkg::MODE_UNPIN: state_next = S_FREAD;
            default:                                    state_next = S_DONE;
          endcase
        end
      end
      S_VREAD: begin
        state_next = S_VEVAL;
      end
      S_VEVAL: begin
        if (status.total_zero) begin
          state_next = S_DONE;
        end else if (!status.slot_ev) begin
          cmd.hand_adv = 1'b1;
          state_next   = S_VREAD;
        end else if (status.slot_ref) begin
          // second chance: drop the reference bit and move on
          cmd.wr_en    = 1'b1;
          cmd.wr_ev    = 1'b1;
          cmd.hand_adv = 1'b1;
          state_next   = S_VREAD;
        end else begin
          cmd.wr_en      = 1'b1;
          cmd.hand_adv   = 1'b1;
          cmd.total_dec  = 1'b1;
          cmd.set_victim = 1'b1;
          state_next     = S_DONE;
        end
      end
      S_FREAD: begin
        cmd.addr_sel = clkpr_pkg::ADDR_FRAME;
        state_next   = S_FEVAL;
      end
      S_FEVAL: begin
        cmd.addr_sel = clkpr_pkg::ADDR_FRAME;
        state_next   = S_DONE;
        if (status.in_range) begin
          if (status.mode == clkpr_pkg::MODE_PIN) begin
            if (status.slot_ev) begin
              cmd.wr_en     = 1'b1;
              cmd.total_dec = 1'b1;
            end
          end else if (status.slot_ev) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_ev  = 1'b1;
            cmd.wr_ref = 1'b1;
          end else if (!status.cap_full) begin
            cmd.wr_en     = 1'b1;
            cmd.wr_ev     = 1'b1;
            cmd.wr_ref    = 1'b1;
            cmd.total_inc = 1'b1;
          end else begin
            cmd.set_refused = 1'b1;
          end
        end
      end
      S_DONE: begin
        // hold until the output word is free
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.load_out || (out_valid && !out_ready);
    end
  end

endmodule

FILE: hw/rtl/clock_page_replacer_top.sv
// Pin and unpin: read in S_FREAD, evaluate in S_FEVAL, load in S_DONE; unused mode: S_DONE only.
// Victim: S_VREAD and S_VEVAL per frame the hand visits (1 to 2*NUM_FRAMES frames), then S_DONE,
// as each visit is a read-then-write turn on the single frame table RAM.
// A finished result waits in the output register while the next word is accepted.
// After reset the frame table is cleared frame by frame with in_ready low;
// configuration writes are taken at any time.
// ----------------------------------------------------------------------------
// clock_page_replacer_top
// Clock (second-chance) page replacer: controller, datapath and frame table.
// ----------------------------------------------------------------------------
module clock_page_replacer_top #(
  parameter int NUM_FRAMES = clkpr_pkg::NUM_FRAMES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [clkpr_pkg::MODE_W-1:0]      mode,
  input  logic [clkpr_pkg::FRAME_W-1:0]     frame,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              victim_valid,
  output logic [clkpr_pkg::FRAME_W-1:0]     victim_frame,
  output logic                              refused,
  output logic [clkpr_pkg::COUNT_W-1:0]     evictable_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [clkpr_pkg::COUNT_W-1:0]     cfg_data
);

  clkpr_pkg::clkpr_cmd_t    cmd;
  clkpr_pkg::clkpr_status_t status;

  assign cfg_ready = 1'b1;

  clkpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  clkpr_datapath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .mode            (mode),
    .frame           (frame),
    .cfg_write       (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .victim_valid    (victim_valid),
    .victim_frame    (victim_frame),
    .refused         (refused),
    .evictable_count (evictable_count)
  );

endmodule

FILE: tb/clock_page_replacer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clock_page_replacer_checker
// Watches the request, result and capacity channels of the clock page
// replacer. It keeps its own copy of the frame table, hand and count, works
// out each result as a request word is taken, and compares every result word
// with the oldest prediction.
// ----------------------------------------------------------------------------
module clock_page_replacer_checker #(
  parameter int NUM_FRAMES = clkpr_pkg::NUM_FRAMES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [clkpr_pkg::MODE_W-1:0]  mode,
  input  logic [clkpr_pkg::FRAME_W-1:0] frame,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          victim_valid,
  input  logic [clkpr_pkg::FRAME_W-1:0] victim_frame,
  input  logic                          refused,
  input  logic [clkpr_pkg::COUNT_W-1:0] evictable_count,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [clkpr_pkg::COUNT_W-1:0] cfg_data,
  output int                            fail_count,
  output int                            pending
);

  typedef struct packed {
    logic                          victim_valid;
    logic [clkpr_pkg::FRAME_W-1:0] victim_frame;
    logic                          refused;
    logic [clkpr_pkg::COUNT_W-1:0] evictable_count;
  } replacer_result_t;

  logic                          evictable_map [NUM_FRAMES];
  logic                          referenced_map [NUM_FRAMES];
  int                            hand_pos;
  logic [clkpr_pkg::COUNT_W-1:0] evictable_total;
  logic [clkpr_pkg::COUNT_W-1:0] capacity;
  replacer_result_t              expected_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic replacer_result_t apply_request(logic [clkpr_pkg::MODE_W-1:0] m,
                                                     logic [clkpr_pkg::FRAME_W-1:0] f);
    replacer_result_t res;
    int               n;
    int               p;
    res = '0;
    case (m)
      clkpr_pkg::MODE_VICTIM: begin
        if (evictable_total != 0) begin
          // sweep: clear reference bits in passing, take the first clear one
          for (n = 0; n < 2 * NUM_FRAMES + 1 && !res.victim_valid; n++) begin
            p = hand_pos;
            hand_pos = (p + 1 >= NUM_FRAMES) ? 0 : p + 1;
            if (evictable_map[p]) begin
              if (referenced_map[p]) begin
                referenced_map[p] = 1'b0;
              end else begin
                evictable_map[p] = 1'b0;
                evictable_total--;
                res.victim_valid = 1'b1;
                res.victim_frame = p[clkpr_pkg::FRAME_W-1:0];
              end
            end
          end
        end
      end
      clkpr_pkg::MODE_PIN: begin
        if (f < NUM_FRAMES && evictable_map[f]) begin
          evictable_map[f]  = 1'b0;
          referenced_map[f] = 1'b0;
          evictable_total--;
        end
      end
      clkpr_pkg::MODE_UNPIN: begin
        if (f < NUM_FRAMES) begin
          if (evictable_map[f]) begin
            referenced_map[f] = 1'b1;
          end else if (evictable_total < capacity) begin
            evictable_map[f]  = 1'b1;
            referenced_map[f] = 1'b1;
            evictable_total++;
          end else begin
            res.refused = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.evictable_count = evictable_total;
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    replacer_result_t want;
    if (rst) begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        evictable_map[i]  = 1'b0;
        referenced_map[i] = 1'b0;
      end
      hand_pos        = 0;
      evictable_total = '0;
      capacity        = clkpr_pkg::CAPACITY_RESET;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no request outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("victim_valid", want.victim_valid, victim_valid);
          check_field("victim_frame", want.victim_frame, victim_frame);
          check_field("refused", want.refused, refused);
          check_field("evictable_count", want.evictable_count, evictable_count);
        end
      end
      if (cfg_valid && cfg_ready)
        capacity = cfg_data;
      if (in_valid && in_ready)
        expected_results.insert(expected_results.size(), apply_request(mode, frame));
    end
    pending <= expected_results.size();
  end

endmodule

FILE: tb/clock_page_replacer_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clock_page_replacer_top_test
// Drives victim, pin and unpin requests into the clock page replacer under
// several capacity settings, with bursty input and a stalling receiver.
// Results are checked by the checker module instantiated beside the block.
// ----------------------------------------------------------------------------
module clock_page_replacer_top_test;

  localparam logic [clkpr_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int                           LONG_HOLD   = 300;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [clkpr_pkg::MODE_W-1:0]  mode = '0;
  logic [clkpr_pkg::FRAME_W-1:0] frame = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          victim_valid;
  logic [clkpr_pkg::FRAME_W-1:0] victim_frame;
  logic                          refused;
  logic [clkpr_pkg::COUNT_W-1:0] evictable_count;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [clkpr_pkg::COUNT_W-1:0] cfg_data = '0;
  int                            fail_count;
  int                            pending;
  int                            sent_words = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  clock_page_replacer_top uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .mode            (mode),
    .frame           (frame),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .victim_valid    (victim_valid),
    .victim_frame    (victim_frame),
    .refused         (refused),
    .evictable_count (evictable_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  clock_page_replacer_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .mode            (mode),
    .frame           (frame),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .victim_valid    (victim_valid),
    .victim_frame    (victim_frame),
    .refused         (refused),
    .evictable_count (evictable_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // Call at a rising edge; returns at the edge that takes the word.
  task automatic send_word(input logic [clkpr_pkg::MODE_W-1:0] m,
                           input logic [clkpr_pkg::FRAME_W-1:0] f);
    in_valid <= 1'b1;
    mode     <= m;
    frame    <= f;
    do @(posedge clk); while (!in_ready);
    sent_words++;
  endtask

  task automatic rest(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_capacity(input logic [clkpr_pkg::COUNT_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input logic [clkpr_pkg::COUNT_W-1:0] cap, input int words);
    int                            left;
    int                            burst;
    int                            gap;
    int                            k;
    int                            pick;
    int                            base;
    int                            span;
    logic [clkpr_pkg::MODE_W-1:0]  m;
    logic [clkpr_pkg::FRAME_W-1:0] f;
    write_capacity(cap);
    // a narrow frame window makes pins and repeat unpins hit evictable frames
    base = $urandom_range(0, 63);
    span = ($urandom_range(0, 1) == 0) ? 12 : 64;
    left = words;
    while (left > 0) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (k = 0; k < burst && left > 0; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)      m = clkpr_pkg::MODE_UNPIN;
        else if (pick < 75) m = clkpr_pkg::MODE_VICTIM;
        else if (pick < 95) m = clkpr_pkg::MODE_PIN;
        else                m = MODE_UNUSED;
        f = 6'((base + $urandom_range(0, span - 1)) % 64);
        send_word(m, f);
        left--;
      end
      gap = $urandom_range(0, 6);
      if (gap != 0)
        rest(gap);
    end
  endtask

  // Receiver: stall in segments of random style, and once hold off long.
  initial begin
    int style;
    int span;
    bit held;
    held = 1'b0;
    forever begin
      style = $urandom_range(0, 2);
      span  = $urandom_range(8, 64);
      repeat (span) begin
        @(posedge clk);
        if (!held && sent_words >= 200) begin
          held = 1'b1;
          out_ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    int start;
    int i;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // capacity at its reset value
    send_word(clkpr_pkg::MODE_VICTIM, 6'd63);
    send_word(clkpr_pkg::MODE_PIN, 6'd0);
    send_word(MODE_UNUSED, 6'd63);
    send_word(clkpr_pkg::MODE_UNPIN, 6'd0);
    send_word(clkpr_pkg::MODE_UNPIN, 6'd63);
    send_word(clkpr_pkg::MODE_UNPIN, 6'd63);
    send_word(clkpr_pkg::MODE_VICTIM, 6'd0);
    send_word(clkpr_pkg::MODE_VICTIM, 6'd21);
    send_word(clkpr_pkg::MODE_UNPIN, 6'd42);
    send_word(clkpr_pkg::MODE_PIN, 6'd42);
    send_word(clkpr_pkg::MODE_VICTIM, 6'd0);

    write_capacity(7'd1);
    send_word(clkpr_pkg::MODE_UNPIN, 6'd5);
    send_word(clkpr_pkg::MODE_UNPIN, 6'd6);
    send_word(clkpr_pkg::MODE_UNPIN, 6'd5);
    send_word(clkpr_pkg::MODE_PIN, 6'd5);

    write_capacity(7'd0);
    send_word(clkpr_pkg::MODE_UNPIN, 6'd7);
    send_word(clkpr_pkg::MODE_VICTIM, 6'd0);

    // fill every frame, then force a full sweep that clears every reference bit
    write_capacity(7'd127);
    start = $urandom_range(0, 63);
    for (i = 0; i < 64; i++)
      send_word(clkpr_pkg::MODE_UNPIN, 6'((start + i) % 64));
    send_word(clkpr_pkg::MODE_VICTIM, 6'd0);

    random_phase(7'd64, 82);
    random_phase(7'd1, 82);
    random_phase(7'd127, 82);
    random_phase(7'd0, 82);
    random_phase(7'd32, 82);
    random_phase(7'($urandom_range(3, 62)), 82);
    random_phase(7'd2, 82);
    random_phase(7'd63, 82);

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
